// ----- rtl/aes_pkg.sv -----
`default_nettype none
package aes_pkg;

  localparam int RoundCountDefault = 10;
  localparam int KeyWordBits = 32;

  localparam logic [0:0] ActEncrypt = 1'b0;
  localparam logic [0:0] ActDecrypt = 1'b1;

  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow = 1'b1;

  typedef struct packed {
    logic       load_key;
    logic       key_step;
    logic       load_block;
    logic       round_step;
    logic       last_round;
    logic       first_dec;
    logic       decrypt;
  } aes_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    gmul = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00)
         ^ (b[3] ? x8 : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    inv_sbox = t[x];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/aes_ram.sv -----
`default_nettype none
module aes_ram #(
  parameter int Width = 128,
  parameter int Depth = 11
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/aes_datapath.sv -----
`default_nettype none
module aes_datapath
  import aes_pkg::*;
#(
  parameter int RoundCount = RoundCountDefault
) (
  input  wire logic                            clk,
  input  wire logic [63:0]                     key_high,
  input  wire logic [63:0]                     key_low,
  input  wire logic [63:0]                     block_high,
  input  wire logic [63:0]                     block_low,
  input  wire aes_cmd_t                        cmd,
  input  wire logic [$clog2(RoundCount+1)-1:0] key_waddr,
  input  wire logic [$clog2(RoundCount+1)-1:0] key_raddr,
  output      logic [127:0]                    state_out
);

  logic [127:0] rkey_r, rkey_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] rd_key;
  logic [127:0] enc_v, dec_v;

  // key expansion, one round key (four words) per step
  always_comb begin
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {sbox(rkey_r[23:16]), sbox(rkey_r[15:8]), sbox(rkey_r[7:0]),
          sbox(rkey_r[31:24])} ^ {rcon_r, 24'h0};
    w0 = rkey_r[127:96] ^ t;
    w1 = rkey_r[95:64] ^ w0;
    w2 = rkey_r[63:32] ^ w1;
    w3 = rkey_r[31:0] ^ w2;
    rkey_nxt = rkey_r;
    rcon_nxt = rcon_r;
    if (cmd.load_key) begin
      rkey_nxt = {key_high, key_low};
      rcon_nxt = 8'h01;
    end else if (cmd.key_step) begin
      rkey_nxt = {w0, w1, w2, w3};
      rcon_nxt = xtime(rcon_r);
    end
  end

  always_ff @(posedge clk) begin
    rkey_r <= rkey_nxt;
    rcon_r <= rcon_nxt;
  end

  aes_ram #(.Width(128), .Depth(RoundCount + 1)) u_key_ram (
    .clk  (clk),
    .we   (cmd.load_key | cmd.key_step),
    .waddr(key_waddr),
    .wdata(cmd.load_key ? {key_high, key_low} : rkey_nxt),
    .raddr(key_raddr),
    .rdata(rd_key)
  );

  // byte i of the block sits at bits 127-8i
  always_comb begin
    logic [7:0] s [16];
    logic [7:0] h [16];
    logic [7:0] m [16];
    for (int i = 0; i < 16; i++) begin
      s[i] = st_r[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        h[r + 4*c] = sbox(s[r + 4*((c + r) & 3)]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        m[4*c + r] = gmul(h[4*c + r], 4'd2) ^ gmul(h[4*c + ((r+1)&3)], 4'd3)
                   ^ h[4*c + ((r+2)&3)] ^ h[4*c + ((r+3)&3)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      enc_v[127-8*i -: 8] = (cmd.last_round ? h[i] : m[i]) ^ rd_key[127-8*i -: 8];
    end
  end

  // inverse round: shift, sub, add key, then inverse mix unless last
  always_comb begin
    logic [7:0] s [16];
    logic [7:0] h [16];
    logic [7:0] m [16];
    for (int i = 0; i < 16; i++) begin
      s[i] = st_r[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        h[r + 4*((c + r) & 3)] = inv_sbox(s[r + 4*c]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      h[i] = h[i] ^ rd_key[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        m[4*c + r] = gmul(h[4*c + r], 4'd14) ^ gmul(h[4*c + ((r+1)&3)], 4'd11)
                   ^ gmul(h[4*c + ((r+2)&3)], 4'd13) ^ gmul(h[4*c + ((r+3)&3)], 4'd9);
      end
    end
    for (int i = 0; i < 16; i++) begin
      dec_v[127-8*i -: 8] = cmd.last_round ? h[i] : m[i];
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (cmd.load_block) begin
      st_nxt = {block_high, block_low};
    end else if (cmd.first_dec || (cmd.round_step && !cmd.decrypt && cmd.first_dec)) begin
      st_nxt = st_r ^ rd_key;
    end else if (cmd.round_step) begin
      st_nxt = cmd.decrypt ? dec_v : enc_v;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign state_out = st_nxt;

endmodule
`default_nettype wire

// ----- rtl/aes_ctrl.sv -----
`default_nettype none
module aes_ctrl
  import aes_pkg::*;
#(
  parameter int RoundCount = RoundCountDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            key_dirty,
  input  wire logic                            in_valid,
  input  wire logic                            in_action,
  output      logic                            in_stall,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic                            load_result,
  output      logic                            sched_done,
  output      aes_cmd_t                        cmd,
  output      logic [$clog2(RoundCount+1)-1:0] key_waddr,
  output      logic [$clog2(RoundCount+1)-1:0] key_raddr
);

  localparam int CntW = $clog2(RoundCount + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(RoundCount);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StKey   = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StFetch = 3'd3;
  localparam logic [2:0] StFirst = 3'd4;
  localparam logic [2:0] StRound = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            dec_r, dec_nxt;
  logic            ov_r, ov_nxt;
  logic            take;
  logic            finish;

  assign take = in_valid && !in_stall;
  assign in_stall = (state_r != StIdle) || (ov_r && out_stall);
  assign out_valid = ov_r;

  // cnt counts processed rounds; read address follows ahead
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    dec_nxt = dec_r;
    cmd = '0;
    cmd.decrypt = dec_r;
    key_waddr = cnt_r;
    key_raddr = dec_r ? CntW'(LastIdx - cnt_r) : cnt_r;
    finish = 1'b0;
    sched_done = 1'b0;
    case (state_r)
      StIdle: begin
        if (take) begin
          dec_nxt = in_action;
          cmd.load_block = 1'b1;
          cnt_nxt = '0;
          if (key_dirty) begin
            cmd.load_key = 1'b1;
            key_waddr = '0;
            cnt_nxt = CntW'(1);
            state_nxt = StKey;
          end else begin
            state_nxt = StFetch;
          end
        end
      end
      StKey: begin
        cmd.key_step = 1'b1;
        if (cnt_r == LastIdx) begin
          cnt_nxt = '0;
          sched_done = 1'b1;
          state_nxt = StFetch;
        end else begin
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      StFetch: begin
        state_nxt = StFirst;
        key_raddr = dec_r ? LastIdx : '0;
        cnt_nxt = CntW'(1);
      end
      StFirst: begin
        cmd.first_dec = 1'b1;
        state_nxt = StRound;
      end
      StRound: begin
        if (cnt_r == LastIdx) begin
          // last round waits while the previous result is still held
          if (!(ov_r && out_stall)) begin
            cmd.round_step = 1'b1;
            cmd.last_round = 1'b1;
            finish = 1'b1;
            state_nxt = StIdle;
          end
        end else begin
          cmd.round_step = 1'b1;
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
    if (state_r == StFirst) begin
      key_raddr = dec_r ? CntW'(LastIdx - CntW'(1)) : CntW'(1);
    end else if (state_r == StRound) begin
      if (cnt_r == LastIdx) begin
        key_raddr = dec_r ? CntW'(LastIdx - cnt_r) : cnt_r;
      end else begin
        key_raddr = dec_r ? CntW'(LastIdx - cnt_r - CntW'(1)) : CntW'(cnt_r + CntW'(1));
      end
    end
  end

  assign load_result = finish;

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (finish) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cnt_r <= '0;
      dec_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      dec_r <= dec_nxt;
      ov_r <= ov_nxt;
    end
  end

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StIdle) |-> in_stall) else $error("input taken while busy");
  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!ov_r || !out_stall)) else $error("result overwritten");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (state_r == StIdle && ov_r)) else $error("finish without result");
`endif

endmodule
`default_nettype wire

// ----- rtl/aes128_block_cipher.sv -----
`default_nettype none
// AES-128 encrypt / decrypt unit.
// cfg port: cfg_we, cfg_index (0 key_high, 1 key_low), cfg_data. Write only
// while idle; a key write forces key expansion on the next input word.
// input word: in_action (0 encrypt, 1 decrypt), in_block_high/low, taken
// when in_valid is high and in_stall low.
// output word: out_result_high/low, held with out_valid until out_stall low.
// From acceptance to out_valid: key fetch, initial key add, ten rounds;
// when the key schedule is rebuilt first, expansion comes before these
// and runs one round key per cycle into the round-key memory.
// One word at a time: the next input is taken the cycle after the result
// register is loaded, if out_stall is low; the pace is set by the
// one-round-per-cycle datapath (the final round waits under out_stall) and
// its single round-key read port.
// A result waiting under out_stall holds the output register; the final
// round waits until it is taken, and the input is stalled while busy or
// while a result is held.
// Reset (rst_n low, synchronous) clears the controller, the result valid and
// the key-ready flag; the keys reset to zero.
module aes128_block_cipher
  import aes_pkg::*;
#(
  parameter int RoundCount = RoundCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_action,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] out_result_high,
  output      logic [63:0] out_result_low
);

  logic [63:0]  key_high_r, key_low_r;
  logic         dirty_r;
  logic         load_result;
  logic         sched_done;
  aes_cmd_t     cmd;
  logic [$clog2(RoundCount+1)-1:0] key_waddr, key_raddr;
  logic [127:0] state_out;
  logic [127:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
      dirty_r <= 1'b1;
    end else begin
      if (cfg_we && cfg_index == CfgKeyHigh) begin
        key_high_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CfgKeyLow) begin
        key_low_r <= cfg_data;
      end
      if (cfg_we) begin
        dirty_r <= 1'b1;
      end else if (sched_done) begin
        dirty_r <= 1'b0;
      end
    end
  end

  aes_ctrl #(.RoundCount(RoundCount)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_dirty  (dirty_r),
    .in_valid   (in_valid),
    .in_action  (in_action),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .load_result(load_result),
    .sched_done (sched_done),
    .cmd        (cmd),
    .key_waddr  (key_waddr),
    .key_raddr  (key_raddr)
  );

  aes_datapath #(.RoundCount(RoundCount)) u_dp (
    .clk       (clk),
    .key_high  (key_high_r),
    .key_low   (key_low_r),
    .block_high(in_block_high),
    .block_low (in_block_low),
    .cmd       (cmd),
    .key_waddr (key_waddr),
    .key_raddr (key_raddr),
    .state_out (state_out)
  );

  // result register loads from the round logic on the final round
  always_ff @(posedge clk) begin
    if (load_result) begin
      res_r <= state_out;
    end
  end

  assign out_result_high = res_r[127:64];
  assign out_result_low = res_r[63:0];

endmodule
`default_nettype wire

// ----- tb/sv/aes128_cipher_checker.sv -----
module aes128_cipher_checker
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_result_high,
  input  logic [63:0] out_result_low,
  output int          error_count,
  output int          pending_count,
  output int          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] key_hi_q, key_lo_q;
  logic [31:0] rk [44];
  logic [127:0] want_q [$];
  logic [7:0] fwd_box [256];
  logic [7:0] inv_box [256];

  function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x ^= 9'h11b;
    end
    return acc;
  endfunction

  function automatic logic [7:0] finv(logic [7:0] v);
    logic [7:0] r, base;
    r = 8'h01;
    base = v;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e & 1) r = fmul(r, base);
      base = fmul(base, base);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  initial begin
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = finv(i[7:0]);
      fwd_box[i] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_box[fwd_box[i]] = i[7:0];
  end

  function automatic void expand_schedule();
    logic [7:0] rc;
    logic [31:0] t;
    rc = 8'h01;
    rk[0] = key_hi_q[63:32];
    rk[1] = key_hi_q[31:0];
    rk[2] = key_lo_q[63:32];
    rk[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = rk[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = fmul(rc, 8'h02);
      end
      rk[i] = rk[i-4] ^ t;
    end
  endfunction

  function automatic logic [127:0] cipher_block(logic dec, logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] col [4];
    logic [7:0] m [4];
    logic [7:0] v;
    logic [127:0] r;
    int rnd;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    if (dec) begin
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int step = 0; step <= 10; step++) begin
      rnd = dec ? 10 - step : step;
      if (step > 0) begin
        t = s;
        for (int c = 0; c < 4; c++)
          for (int rr = 0; rr < 4; rr++) begin
            if (dec) s[rr + 4*((c+rr)%4)] = t[rr + 4*c];
            else s[rr + 4*c] = t[rr + 4*((c+rr)%4)];
          end
        for (int i = 0; i < 16; i++) s[i] = dec ? inv_box[s[i]] : fwd_box[s[i]];
        if (dec) begin
          t = s;
          s = '{default: 8'h00};
          for (int i = 0; i < 16; i++) s[i] = t[i];
        end else begin
          if (step != 10) begin
            for (int c = 0; c < 4; c++) begin
              for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
              for (int rr = 0; rr < 4; rr++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= fmul(col[k], m[(k - rr + 4) % 4]);
                s[4*c+rr] = v;
              end
            end
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int rr = 0; rr < 4; rr++) s[4*c+rr] ^= rk[4*rnd+c][31-8*rr -: 8];
      if (dec && step > 0 && step != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
          for (int rr = 0; rr < 4; rr++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= fmul(col[k], m[(k - rr + 4) % 4]);
            s[4*c+rr] = v;
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  always @(posedge clk) begin
    logic [127:0] exp_w;
    int errs;
    errs = 0;
    if (!rst_n) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      want_q.delete();
      error_count <= 0;
      checked_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgKeyHigh) key_hi_q <= cfg_data;
        else key_lo_q <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        expand_schedule();
        want_q.push_back(cipher_block(in_action, {in_block_high, in_block_low}));
      end
      if (out_valid && !out_stall) begin
        checked_count <= checked_count + 1;
        if (want_q.size() == 0) begin
          $error("unexpected result word %h %h", out_result_high, out_result_low);
          errs++;
        end else begin
          exp_w = want_q.pop_front();
          if (out_result_high !== exp_w[127:64]) begin
            $error("result_high expected %h got %h", exp_w[127:64], out_result_high);
            errs++;
          end
          if (out_result_low !== exp_w[63:0]) begin
            $error("result_low expected %h got %h", exp_w[63:0], out_result_low);
            errs++;
          end
        end
      end
      error_count <= error_count + errs;
      pending_count <= want_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_aes128_block_cipher.sv -----
module tb_aes128_block_cipher
  import aes_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  int          error_count;
  int          pending_count;
  int          checked_count;
  bit          quiet_phase;
  int          enc_count;
  int          dec_count;

  aes128_block_cipher i_dut (.*);

  aes128_cipher_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("tb_aes128_block_cipher: errors");
    $finish;
  end

  // receiver stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_word(input logic act, input logic [63:0] hi, input logic [63:0] lo);
    int n;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_block_high <= hi;
    in_block_low <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ActDecrypt) dec_count++;
    else enc_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_0000_0001;
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] hi, lo;
    quiet_phase = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgKeyHigh;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ActEncrypt;
    in_block_high = '0;
    in_block_low = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key of zero, extreme blocks both ways
    send_word(ActEncrypt, '0, '0);
    send_word(ActDecrypt, '0, '0);
    send_word(ActEncrypt, '1, '1);
    send_word(ActDecrypt, '1, '1);
    wait_drained();

    // standard test vector key
    write_key(CfgKeyHigh, 64'h0001_0203_0405_0607);
    write_key(CfgKeyLow, 64'h0809_0a0b_0c0d_0e0f);
    send_word(ActEncrypt, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_word(ActDecrypt, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    send_word(ActEncrypt, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    wait_drained();

    write_key(CfgKeyHigh, '1);
    write_key(CfgKeyLow, '1);
    send_word(ActEncrypt, '0, '1);
    send_word(ActDecrypt, '1, '0);
    wait_drained();

    // only one half rewritten
    write_key(CfgKeyLow, '0);
    send_word(ActEncrypt, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_word(ActDecrypt, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    wait_drained();

    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 20) quiet_phase = 1'b1;
      if ($urandom_range(0, 3) != 0) write_key(CfgKeyHigh, pick_edge());
      if ($urandom_range(0, 3) != 0) write_key(CfgKeyLow, pick_edge());
      for (int k = 0; k < 58; k++) begin
        hi = ($urandom_range(0, 9) == 0) ? pick_edge() : rand64();
        lo = ($urandom_range(0, 9) == 0) ? pick_edge() : rand64();
        send_word(1'($urandom_range(0, 1)), hi, lo);
      end
      wait_drained();
    end

    $display("covered %0d encrypt and %0d decrypt words, %0d results checked",
             enc_count, dec_count, checked_count);
    $display("keys: zero, all ones, the standard vector and random, changed per phase");
    if (error_count == 0) begin
      $display("tb_aes128_block_cipher: clean");
    end else begin
      $display("tb_aes128_block_cipher: errors");
    end
    $finish;
  end
endmodule
